// File: hdl/dad_pkg.sv
// Shared types, constants and month-length helpers for the date-add-days unit.
// No dependencies.
package dad_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned ADD_W   = 15;
    localparam int unsigned REM_W   = 16;  // day count, worst case ~33200
    localparam int unsigned YINT_W  = 15;  // internal year, room for carry past 16383
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned MOD_W   = 9;   // year mod 400
    localparam int unsigned STEP_W  = 3;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [YEAR_W-1:0]  CYCLE_YEARS = YEAR_W'(400);
    localparam logic [STEP_W-1:0]  MOD_STEPS   = STEP_W'(5);  // 400 << 6 > 16383
    localparam logic [MOD_W-1:0]   MOD_LAST    = MOD_W'(399);
    localparam logic [MONTH_W-1:0] JANUARY     = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY    = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER    = MONTH_W'(12);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MOD  = 5'b00010,
        ST_DOY  = 5'b00100,
        ST_WALK = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    // y mod 4 == 0 and not a century, unless a multiple of 400.
    function automatic logic is_leap(input logic [1:0] y_low, input logic [MOD_W-1:0] y_mod400);
        logic century;
        century = y_mod400 inside {MOD_W'(100), MOD_W'(200), MOD_W'(300)};
        return (y_low == 2'd0) && !century;
    endfunction

    // Months outside 1..12 count as zero days.
    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [LEN_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = LEN_W'(30);
            FEBRUARY: len = leap ? LEN_W'(29) : LEN_W'(28);
            default:  len = '0;
        endcase
        return len;
    endfunction

endpackage

// File: hdl/date_add_days_unit.sv
// Adds a day count to a Gregorian date with one shared add/subtract unit under a sequencer.
// Depends on dad_pkg.
//
// Sequence: accept, reduce the year modulo 400, accumulate the day of year over the months
//   before start_month, walk month by month, then register the output (held while it stalls).
// Throughput: one request at a time; the month walk, one month per cycle, sets the rate.
// Reset: synchronous, active low; returns to idle and drops the output valid.
module date_add_days_unit
    import dad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], days_to_add[37:23], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // end_year[13:0], end_month[17:14], end_day[22:18], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_state               r_state, n_state;
    logic [YINT_W-1:0]    r_year, n_year;
    logic [YEAR_W-1:0]    r_ymod, n_ymod;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [MONTH_W-1:0]   r_smon, n_smon;
    logic [MONTH_W-1:0]   r_mon, n_mon;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                 leap;
    logic [LEN_W-1:0]     len;
    logic [REM_W-1:0]     alu_opb;
    logic                 alu_sub;
    logic [REM_W-1:0]     alu_res;
    logic [YEAR_W:0]      mod_diff;
    logic                 out_free;

    assign leap = is_leap(r_year[1:0], r_ymod[MOD_W-1:0]);
    assign len  = month_len(r_mon, leap);

    // Shared unit: accumulates month lengths, then peels them off.
    assign alu_sub = (r_state == ST_WALK);
    assign alu_opb = REM_W'(len);
    assign alu_res = alu_sub ? (r_rem - alu_opb) : (r_rem + alu_opb);

    // Restoring reduction of the start year modulo 400.
    assign mod_diff = {1'b0, r_ymod} - {1'b0, YEAR_W'(CYCLE_YEARS << r_step)};

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_year      = r_year;
        n_ymod      = r_ymod;
        n_step      = r_step;
        n_smon      = r_smon;
        n_mon       = r_mon;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_year  = YINT_W'(s_axis_tdata[13:0]);
                    n_ymod  = s_axis_tdata[13:0];
                    n_smon  = s_axis_tdata[17:14];
                    n_rem   = REM_W'(s_axis_tdata[22:18]) + REM_W'(s_axis_tdata[37:23]);
                    n_step  = MOD_STEPS;
                    n_mon   = JANUARY;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (!mod_diff[YEAR_W]) begin
                    n_ymod = mod_diff[YEAR_W-1:0];
                end
                if (r_step == '0) begin
                    n_state = ST_DOY;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            ST_DOY: begin
                if (r_mon < r_smon) begin
                    n_rem = alu_res;
                    n_mon = r_mon + MONTH_W'(1);
                end else begin
                    n_mon   = JANUARY;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_rem > REM_W'(len)) begin
                    n_rem = alu_res;
                    if (r_mon == DECEMBER) begin
                        n_mon  = JANUARY;
                        n_year = r_year + YINT_W'(1);
                        n_ymod = (r_ymod[MOD_W-1:0] == MOD_LAST) ? '0
                               : YEAR_W'(r_ymod[MOD_W-1:0] + MOD_W'(1));
                    end else begin
                        n_mon = r_mon + MONTH_W'(1);
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_rem[DAY_W-1:0], r_mon, r_year[YEAR_W-1:0]};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_year     <= n_year;
        r_ymod     <= n_ymod;
        r_step     <= n_step;
        r_smon     <= n_smon;
        r_mon      <= n_mon;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
    end

endmodule

// File: bench/tb_date_add_days_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for date_add_days_unit: stream requests in, predicted dates checked out.
// Depends on dad_pkg and the date_add_days_unit RTL.
module tb_date_add_days_unit
    import dad_pkg::*;
();

    localparam int unsigned RANDOM_PER_PHASE = 172;
    localparam int unsigned HOLD_CYCLES      = 3000;
    localparam int unsigned WATCHDOG_LIMIT   = 20000;
    localparam int unsigned DRAIN_CYCLES     = 40;
    localparam int unsigned MONTHS_PER_YEAR  = 12;
    localparam int unsigned MAX_YEAR_IN      = (1 << YEAR_W) - 1;
    localparam int unsigned MAX_DAYS_IN      = (1 << ADD_W) - 1;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_date;

    class t_date_scoreboard;
        t_date       expected_dates[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        // Months outside 1..12 have no days.
        function int unsigned month_days(int unsigned mon, int unsigned y);
            case (mon)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        function t_date add_days(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                 logic [DAY_W-1:0] d, logic [ADD_W-1:0] n);
            int unsigned year;
            int unsigned remaining;
            int unsigned mon;
            t_date       r;
            year      = y;
            remaining = int'(d) + int'(n);
            for (mon = 1; mon < m; mon++)
                remaining += month_days(mon, year);
            mon = 1;
            while (remaining > month_days(mon, year)) begin
                remaining -= month_days(mon, year);
                mon++;
                if (mon > MONTHS_PER_YEAR) begin
                    mon = 1;
                    year++;
                end
            end
            r.year  = YEAR_W'(year);
            r.month = MONTH_W'(mon);
            r.day   = DAY_W'(remaining);
            return r;
        endfunction

        function void note_request(logic [IN_DATA_W-1:0] req);
            expected_dates.push_back(add_days(req[13:0], req[17:14], req[22:18], req[37:23]));
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] res);
            t_date want;
            t_date got;
            got = res[22:0];
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("result %0d-%0d-%0d with no request pending",
                                          got.year, got.month, got.day));
            end else begin
                want = expected_dates.pop_front();
                if (got.year != want.year || got.month != want.month || got.day != want.day)
                    report_mismatch($sformatf("got %0d-%0d-%0d, want %0d-%0d-%0d",
                                              got.year, got.month, got.day,
                                              want.year, want.month, want.day));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire [OUT_DATA_W-1:0]  m_axis_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        rx_hold = 1'b0;
    logic        stall_start = 1'b0;
    int unsigned quiet_cycles = 0;
    t_date_scoreboard sb;

    date_add_days_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver stall so the unit backs up and holds off new requests.
    initial begin
        wait (stall_start);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_tready)
            sb.check_result(m_axis_tdata);
        if (rst_n && s_tvalid && s_axis_tready)
            sb.note_request(s_tdata);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL date_add_days_unit");
            $finish;
        end
    end

    task set_idling(int unsigned tx_pct, int unsigned rx_pct);
        send_idle_pct = tx_pct;
        recv_idle_pct <= rx_pct;
    endtask

    task send_request(int unsigned y, int unsigned m, int unsigned d, int unsigned n);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ADD_W'(n), DAY_W'(d), MONTH_W'(m), YEAR_W'(y)};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Mostly well-formed dates and short spans; a share of odd fields and long spans.
    task send_random_request();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned n;
        int unsigned pick;
        y = ($urandom_range(99) < 80) ? $urandom_range(9999) : $urandom_range(MAX_YEAR_IN);
        m = ($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(15);
        d = ($urandom_range(99) < 80) ? $urandom_range(28, 1) : $urandom_range(31);
        pick = $urandom_range(99);
        if (pick < 60)
            n = $urandom_range(400);
        else if (pick < 80)
            n = $urandom_range(4000);
        else
            n = $urandom_range(MAX_DAYS_IN);
        send_request(y, m, d, n);
    endtask

    task run_directed();
        send_request(2000, 1, 0, 0);          // zero total
        send_request(2000, 0, 0, 0);          // zero total, month zero
        send_request(1999, 0, 15, 100);       // month zero with days
        send_request(2023, 13, 1, 0);         // months past December
        send_request(2024, 15, 31, 500);
        send_request(2000, 14, 0, 10);
        send_request(2023, 2, 31, 0);         // day beyond month length
        send_request(2023, 4, 0, 1);          // day zero
        send_request(2000, 2, 28, 1);         // century leap year
        send_request(1900, 2, 28, 1);         // century, not leap
        send_request(2024, 2, 28, 1);
        send_request(2023, 2, 28, 1);
        send_request(2100, 2, 29, 0);
        send_request(0, 1, 1, 365);           // year zero is leap
        send_request(2023, 12, 31, 1);        // December rollover
        send_request(2023, 12, 31, 0);
        send_request(9999, 12, 31, MAX_DAYS_IN);
        send_request(MAX_YEAR_IN, 15, 31, MAX_DAYS_IN);  // year wraps
        send_request(MAX_YEAR_IN, 12, 31, 1);
        send_request(0, 0, 0, MAX_DAYS_IN);
        send_request(0, 1, 1, 0);
        send_request(1, 1, 1, MAX_DAYS_IN);
        send_request(5461, 10, 21, 10922);    // alternating bit patterns
    endtask

    initial begin
        int unsigned i;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(31, 83);
        run_directed();
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_request();

        set_idling(83, 31);
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_request();

        set_idling(0, 0);
        for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i == 10)
                stall_start <= 1'b1;
            send_random_request();
        end
        s_tvalid <= 1'b0;

        while (sb.expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0) begin
            $display("PASS date_add_days_unit");
        end else begin
            $display("FAIL date_add_days_unit");
        end
        $finish;
    end

endmodule
